/* design/hqr_pkg.sv */
package hqr_pkg;

  localparam int MAX_ORDER = 8;
  localparam int LIM_ORDER = (MAX_ORDER < 8) ? MAX_ORDER : 8;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int RHS_COL   = MAX_ORDER;
  localparam int ADDR_W    = IDX_W + ORD_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_SOLVE  = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_COPY, S_COL_START, S_NRM_RD, S_NRM_MUL, S_NRM_ACC,
    S_SQRT_GO, S_SQRT, S_VTV_MUL, S_VTV_ACC, S_VTV_CHK,
    S_DOT_START, S_DOT_RD, S_DOT_MUL, S_DOT_ACC,
    S_SHIFT_INIT, S_SHIFT, S_DIV_W,
    S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_PIVOT,
    S_BS_START, S_BS_B, S_BS_D, S_BS_RD, S_BS_MUL, S_BS_ACC,
    S_BS_DIV_GO, S_BS_DIV_W, S_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

/* design/hqr_ram.sv */
module hqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/hqr_div.sv */
module hqr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hqr_pkg::div_req_t req,
  output hqr_pkg::div_rsp_t rsp
);
  import hqr_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[63]};
    diff     = shifted - {1'b0, dsr_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dsr_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* design/hqr_isqrt.sv */
module hqr_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);
  import hqr_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] diff;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {1'b0, res_r} + {1'b0, bit_r};
    diff     = {1'b0, rem_r} - trial;
    if (start) begin
      rem_nxt = x;
      res_nxt = '0;
      bit_nxt = 64'd1 << 62;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

/* design/householder_qr_linear_solve.sv */
// Loads are taken one per cycle, back to back, while not busy; a solve holds busy until its last result.
// Solve: a copy sweep into the work store; per column the norm, the square root and
// v'v; per reflected column the dot product and update, with scaling and a divider
// run for the weight. Back substitution per row: b and the diagonal, each term, then
// the divider. Results leave on consecutive cycles; no receiver stall.
// Synchronous active-low reset returns to idle with order 8; the stores are not cleared.
module householder_qr_linear_solve (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_row_index,
  input  logic [2:0]         in_col_index,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic [2:0]         out_sol_index,
  output logic signed [31:0] out_sol_value,
  output logic               out_singular,
  output logic               out_last
);
  import hqr_pkg::*;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  state_t state_r, state_nxt;
  logic [3:0]          size_r;
  logic [ORD_W-1:0]    n_r, n_nxt, k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   cp_addr_r, cp_addr_nxt;
  logic                cp_vld_r, cp_vld_nxt;
  logic                sing_r, sing_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         sq_r, sq_nxt, vtv_r, vtv_nxt, ud_r, ud_nxt, uv_r, uv_nxt;
  logic signed [63:0]  dot_r, dot_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic signed [31:0]  x0_r, x0_nxt, alpha_r, alpha_nxt, w_r, w_nxt;
  logic signed [31:0]  p_r, p_nxt, d_r, d_nxt;
  logic signed [31:0]  v_r [MAX_ORDER];
  logic signed [31:0]  v_nxt [MAX_ORDER];
  logic signed [31:0]  sol_r [MAX_ORDER];
  logic signed [31:0]  sol_nxt [MAX_ORDER];

  logic                l_we, w_we;
  logic [ADDR_W-1:0]   l_waddr, l_raddr, w_waddr, w_raddr;
  logic [DATA_W-1:0]   l_wdata, l_rdata, w_wdata, w_rdata;
  logic signed [31:0]  mul_a, mul_b, wrd, v_i, sol_j, nrm, abs_q;
  logic [ORD_W-1:0]    cur_col, n_m1;
  logic signed [63:0]  tq, upd, sum0, abs_d;
  logic [63:0]         abs_acc;
  logic                sq_start, sq_done;
  logic [31:0]         sq_root;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                accept;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ORD_W-1:0] row,
                                                input logic [ORD_W-1:0] col);
    addr_of = {row[IDX_W-1:0], col};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(S32_MAX)) sat32 = S32_MAX;
    else if (x < 64'(S32_MIN)) sat32 = S32_MIN;
    else sat32 = x[31:0];
  endfunction

  function automatic logic [63:0] uaddsat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    uaddsat = s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [63:0] addsat(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) addsat = S64_MAX;
    else if (s < -65'(S64_MAX)) addsat = -S64_MAX;
    else addsat = s[63:0];
  endfunction

  hqr_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_load_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  hqr_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_work_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  hqr_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(sq_r), .done(sq_done), .root(sq_root)
  );

  hqr_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign wrd     = w_rdata;
  assign n_m1    = n_r - ORD_W'(1);
  assign cur_col = (j_r == n_r) ? ORD_W'(RHS_COL) : j_r;
  assign v_i     = v_r[i_r[IDX_W-1:0]];
  assign sol_j   = sol_r[j_r[IDX_W-1:0]];
  assign nrm     = sq_root[31] ? S32_MAX : sq_root;
  assign sum0    = 64'(x0_r) + 64'(x0_r[31] ? -nrm : nrm);
  assign tq      = prod_r[63] ? -64'((-prod_r) >>> 16) : (prod_r >>> 16);
  assign upd     = 64'(p_r) - tq;
  assign abs_acc = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
  assign abs_d   = d_r[31] ? -64'(d_r) : 64'(d_r);
  assign abs_q   = -div_rsp.quotient[31:0];

  assign l_we    = accept && ((in_command == CMD_LOAD_A) || (in_command == CMD_LOAD_B));
  assign l_waddr = addr_of(ORD_W'(in_row_index),
                           (in_command == CMD_LOAD_A) ? ORD_W'(in_col_index)
                                                      : ORD_W'(RHS_COL));
  assign l_wdata = in_value;
  assign l_raddr = cnt_r[ADDR_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    cp_addr_nxt = cp_addr_r;
    cp_vld_nxt  = 1'b0;
    sing_nxt    = sing_r;
    neg_nxt     = neg_r;
    sq_nxt      = sq_r;
    vtv_nxt     = vtv_r;
    ud_nxt      = ud_r;
    uv_nxt      = uv_r;
    dot_nxt     = dot_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    x0_nxt      = x0_r;
    alpha_nxt   = alpha_r;
    w_nxt       = w_r;
    p_nxt       = p_r;
    d_nxt       = d_r;
    v_nxt       = v_r;
    sol_nxt     = sol_r;
    w_we        = 1'b0;
    w_waddr     = cp_addr_r;
    w_wdata     = l_rdata;
    w_raddr     = '0;
    mul_a       = v_i;
    mul_b       = v_i;
    sq_start    = 1'b0;
    div_req     = '{start: 1'b0, dividend: {ud_r[46:0], 17'b0}, divisor: uv_r};
    out_strobe  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_SOLVE) begin
          if (size_r == 4'd0) n_nxt = ORD_W'(1);
          else if (int'(size_r) > LIM_ORDER) n_nxt = ORD_W'(LIM_ORDER);
          else n_nxt = ORD_W'(size_r);
          k_nxt     = '0;
          cnt_nxt   = '0;
          sing_nxt  = 1'b0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        w_we = cp_vld_r;
        if (cnt_r < (ADDR_W+1)'(RAM_DEPTH)) begin
          cp_vld_nxt  = 1'b1;
          cp_addr_nxt = cnt_r[ADDR_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          state_nxt = S_COL_START;
        end
      end
      S_COL_START: begin
        sq_nxt    = '0;
        i_nxt     = k_r;
        state_nxt = S_NRM_RD;
      end
      S_NRM_RD: begin
        w_raddr   = addr_of(i_r, k_r);
        state_nxt = S_NRM_MUL;
      end
      S_NRM_MUL: begin
        mul_a = wrd;
        mul_b = wrd;
        prod_nxt = mul_a * mul_b;
        v_nxt[i_r[IDX_W-1:0]] = wrd;
        if (i_r == k_r) x0_nxt = wrd;
        state_nxt = S_NRM_ACC;
      end
      S_NRM_ACC: begin
        sq_nxt = uaddsat(sq_r, prod_r);
        if (i_r == n_m1) begin
          state_nxt = S_SQRT_GO;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_NRM_RD;
        end
      end
      S_SQRT_GO: begin
        sq_start  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          alpha_nxt = x0_r[31] ? -nrm : nrm;
          v_nxt[k_r[IDX_W-1:0]] = sat32(sum0);
          i_nxt     = k_r;
          vtv_nxt   = '0;
          state_nxt = S_VTV_MUL;
        end
      end
      S_VTV_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_VTV_ACC;
      end
      S_VTV_ACC: begin
        vtv_nxt = uaddsat(vtv_r, prod_r);
        if (i_r == n_m1) begin
          state_nxt = S_VTV_CHK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_VTV_MUL;
        end
      end
      S_VTV_CHK: begin
        if (vtv_r == '0) begin
          sing_nxt = 1'b1;
          if (k_r == n_m1) begin
            i_nxt     = n_m1;
            state_nxt = S_BS_START;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_COL_START;
          end
        end else begin
          j_nxt     = k_r + 1'b1;
          state_nxt = S_DOT_START;
        end
      end
      S_DOT_START: begin
        dot_nxt   = '0;
        i_nxt     = k_r;
        state_nxt = S_DOT_RD;
      end
      S_DOT_RD: begin
        w_raddr   = addr_of(i_r, cur_col);
        state_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        mul_b     = wrd;
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        dot_nxt = addsat(dot_r, prod_r);
        if (i_r == n_m1) begin
          state_nxt = S_SHIFT_INIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_DOT_RD;
        end
      end
      S_SHIFT_INIT: begin
        neg_nxt   = dot_r[63];
        ud_nxt    = dot_r[63] ? 64'(-dot_r) : 64'(dot_r);
        uv_nxt    = vtv_r;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        i_nxt = k_r;
        if (|ud_r[63:46]) begin
          ud_nxt = ud_r >> 1;
          uv_nxt = uv_r >> 1;
        end else if (uv_r == '0) begin
          w_nxt     = neg_r ? S32_MIN : S32_MAX;
          state_nxt = S_UPD_RD;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (div_rsp.done) begin
          if (|div_rsp.quotient[63:31]) w_nxt = neg_r ? S32_MIN : S32_MAX;
          else w_nxt = neg_r ? abs_q : div_rsp.quotient[31:0];
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        w_raddr   = addr_of(i_r, cur_col);
        state_nxt = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        mul_b     = w_r;
        prod_nxt  = mul_a * mul_b;
        p_nxt     = wrd;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        w_we    = 1'b1;
        w_waddr = addr_of(i_r, cur_col);
        w_wdata = sat32(upd);
        if (i_r != n_m1) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_UPD_RD;
        end else if (j_r == n_r) begin
          state_nxt = S_PIVOT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DOT_START;
        end
      end
      S_PIVOT: begin
        w_we    = 1'b1;
        w_waddr = addr_of(k_r, k_r);
        w_wdata = -alpha_r;
        if (k_r == n_m1) begin
          i_nxt     = n_m1;
          state_nxt = S_BS_START;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_COL_START;
        end
      end
      S_BS_START: begin
        w_raddr   = addr_of(i_r, ORD_W'(RHS_COL));
        state_nxt = S_BS_B;
      end
      S_BS_B: begin
        acc_nxt   = {{16{wrd[31]}}, wrd, 16'b0};
        w_raddr   = addr_of(i_r, i_r);
        state_nxt = S_BS_D;
      end
      S_BS_D: begin
        d_nxt = wrd;
        j_nxt = i_r + 1'b1;
        state_nxt = (i_r == n_m1) ? S_BS_DIV_GO : S_BS_RD;
      end
      S_BS_RD: begin
        w_raddr   = addr_of(i_r, j_r);
        state_nxt = S_BS_MUL;
      end
      S_BS_MUL: begin
        mul_a     = wrd;
        mul_b     = sol_j;
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_BS_ACC;
      end
      S_BS_ACC: begin
        acc_nxt = addsat(acc_r, -prod_r);
        if (j_r == n_m1) begin
          state_nxt = S_BS_DIV_GO;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_BS_RD;
        end
      end
      S_BS_DIV_GO: begin
        if (d_r == '0) begin
          sing_nxt = 1'b1;
          sol_nxt[i_r[IDX_W-1:0]] = '0;
          if (i_r == '0) begin
            j_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_BS_START;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = abs_acc;
          div_req.divisor  = abs_d;
          state_nxt        = S_BS_DIV_W;
        end
      end
      S_BS_DIV_W: begin
        if (div_rsp.done) begin
          if (acc_r[63] ^ d_r[31]) begin
            sol_nxt[i_r[IDX_W-1:0]] = (|div_rsp.quotient[63:31]) ? S32_MIN : abs_q;
          end else begin
            sol_nxt[i_r[IDX_W-1:0]] = (|div_rsp.quotient[63:31]) ? S32_MAX
                                                                 : div_rsp.quotient[31:0];
          end
          if (i_r == '0) begin
            j_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_BS_START;
          end
        end
      end
      S_EMIT: begin
        out_strobe = 1'b1;
        if (j_r == n_m1) begin
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_sol_index = 3'(j_r);
  assign out_sol_value = sol_j;
  assign out_singular  = sing_r;
  assign out_last      = out_strobe && (j_r == n_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= 4'd8;
      cp_vld_r <= 1'b0;
      sing_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_data;
      end
      cp_vld_r <= cp_vld_nxt;
      sing_r   <= sing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    cnt_r     <= cnt_nxt;
    cp_addr_r <= cp_addr_nxt;
    neg_r     <= neg_nxt;
    sq_r      <= sq_nxt;
    vtv_r     <= vtv_nxt;
    ud_r      <= ud_nxt;
    uv_r      <= uv_nxt;
    dot_r     <= dot_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    x0_r      <= x0_nxt;
    alpha_r   <= alpha_nxt;
    w_r       <= w_nxt;
    p_r       <= p_nxt;
    d_r       <= d_nxt;
    v_r       <= v_nxt;
    sol_r     <= sol_nxt;
  end

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result transfer while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !busy)
    else $error("still busy after final result");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_SOLVE) |=> busy)
    else $error("solve accepted without going busy");

  a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (out_strobe && out_sol_index == $past(out_sol_index) + 3'd1))
    else $error("solution entries not consecutive");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !w_we)
    else $error("work memory written while idle");

endmodule

/* tb/householder_qr_linear_solve_test.sv */
`timescale 1ns / 100ps

module householder_qr_linear_solve_test;
  import hqr_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    logic [2:0]        idx;
    logic signed [31:0] val;
    logic              sing;
    logic              last;
  } sol_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  cmd;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] val;
    bit          typed;
    logic [31:0] xval;
    bit          xsing;
  } row_t;

  logic clk, rst_n, cfg_we, start, busy;
  logic [3:0] cfg_data;
  logic [1:0] in_command;
  logic [2:0] in_row_index, in_col_index;
  logic signed [31:0] in_value;
  logic out_strobe, out_singular, out_last;
  logic [2:0] out_sol_index;
  logic signed [31:0] out_sol_value;

  householder_qr_linear_solve dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .in_command(in_command),
    .in_row_index(in_row_index), .in_col_index(in_col_index), .in_value(in_value),
    .out_strobe(out_strobe), .out_sol_index(out_sol_index),
    .out_sol_value(out_sol_value), .out_singular(out_singular), .out_last(out_last)
  );

  // model state
  logic signed [31:0] mat [8][8];
  logic signed [31:0] rhs [8];
  longint solved [8];
  bit wa [8][8];
  bit wb [8];
  logic [3:0] order_reg;
  sol_t pending [$];
  int errors, items, burst_left;
  bit gappy, typed_on, typed_sing;
  logic [31:0] typed_val;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mulq(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return p >>> 16;
    return -((-p) >>> 16);
  endfunction

  function automatic longint addsat(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < -S64_MAX - b) return -S64_MAX;
    return a + b;
  endfunction

  function automatic longint unsigned uaddsat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint reflect_weight(longint dot, longint unsigned vtv);
    bit neg;
    longint unsigned ud, uv, q;
    neg = dot < 0;
    ud = neg ? longint'(-dot) : dot;
    uv = vtv;
    while (ud >= (64'd1 << 46)) begin
      ud = ud >> 1;
      uv = uv >> 1;
    end
    if (uv == 0) q = 64'd1 << 31;
    else q = (ud << 17) / uv;
    if (q > (64'd1 << 31)) q = 64'd1 << 31;
    return sat32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic void solve_system();
    longint a [8][8];
    longint b [8];
    longint v [8];
    longint unsigned sq, vtv, nrm;
    longint x0, alpha, dot, w, e, acc, d;
    int n;
    bit sing;
    sol_t s;
    sing = 0;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    if (n > 8) n = 8;
    for (int i = 0; i < 8; i++) begin
      b[i] = rhs[i];
      for (int j = 0; j < 8; j++) a[i][j] = mat[i][j];
    end
    for (int k = 0; k < n; k++) begin
      sq = 0;
      vtv = 0;
      x0 = a[k][k];
      for (int i = k; i < n; i++) sq = uaddsat(sq, a[i][k] * a[i][k]);
      nrm = isqrt(sq);
      if (nrm > 64'd2147483647) nrm = 64'd2147483647;
      alpha = (x0 >= 0) ? longint'(nrm) : -longint'(nrm);
      for (int i = k; i < n; i++) v[i] = a[i][k];
      v[k] = sat32(x0 + alpha);
      for (int i = k; i < n; i++) vtv = uaddsat(vtv, v[i] * v[i]);
      if (vtv == 0) begin
        sing = 1;
        continue;
      end
      for (int j = k + 1; j <= n; j++) begin
        dot = 0;
        for (int i = k; i < n; i++) begin
          e = (j < n) ? a[i][j] : b[i];
          dot = addsat(dot, v[i] * e);
        end
        w = reflect_weight(dot, vtv);
        for (int i = k; i < n; i++) begin
          if (j < n) a[i][j] = sat32(a[i][j] - mulq(v[i], w));
          else b[i] = sat32(b[i] - mulq(v[i], w));
        end
      end
      a[k][k] = sat32(-alpha);
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = b[i] * 65536;
      d = a[i][i];
      for (int j = i + 1; j < n; j++) acc = addsat(acc, -(a[i][j] * solved[j]));
      if (d == 0) begin
        sing = 1;
        solved[i] = 0;
      end else begin
        solved[i] = sat32(acc / d);
      end
    end
    for (int k = 0; k < n; k++) begin
      s.idx = k[2:0];
      s.val = solved[k][31:0];
      s.sing = sing;
      s.last = (k == n - 1);
      if (typed_on) begin
        s.val = typed_val;
        s.sing = typed_sing;
      end
      pending = {pending, s};
    end
  endfunction

  function automatic void apply_transfer(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                                         logic [31:0] val);
    case (cmd)
      CMD_LOAD_A: begin
        mat[r][c] = val;
        wa[r][c] = 1;
      end
      CMD_LOAD_B: begin
        rhs[r] = val;
        wb[r] = 1;
      end
      CMD_SOLVE: solve_system();
      default: ;
    endcase
    if (cmd != CMD_IGNORED) items++;
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [2:0] r, input logic [2:0] c,
                      input logic [31:0] val);
    if (gappy && burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    start = 1'b1;
    in_command = cmd;
    in_row_index = r;
    in_col_index = c;
    in_value = val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    apply_transfer(cmd, r, c, val);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending.size() != 0 || busy) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_order(input logic [3:0] n);
    settle();
    cfg_we = 1'b1;
    cfg_data = n;
    @(negedge clk);
    cfg_we = 1'b0;
    order_reg = n;
  endtask

  function automatic logic [31:0] pick_value(int style, bit diag);
    case (style)
      0: begin
        if (diag) return $urandom_range(0, 1) ? $urandom_range(32'h80000, 32'h400000)
                                              : -$urandom_range(32'h80000, 32'h400000);
        return $urandom_range(0, 32'h20000) - 32'h10000;
      end
      1: return $urandom_range(0, 32'h80000) - 32'h40000;
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          4: return 32'h1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic row_t mk(bit is_cfg, logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                              logic [31:0] val, bit typed = 0, logic [31:0] xval = 0,
                              bit xsing = 0);
    row_t t;
    t.is_cfg = is_cfg;
    t.cmd = cmd;
    t.r = r;
    t.c = c;
    t.val = val;
    t.typed = typed;
    t.xval = xval;
    t.xsing = xsing;
    return t;
  endfunction

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    sol_t x;
    if (rst_n && out_strobe) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx %0d value %h", out_sol_index,
                                   out_sol_value);
      end else begin
        x = pending.pop_front();
        if (out_sol_index !== x.idx || out_sol_value !== x.val ||
            out_singular !== x.sing || out_last !== x.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp idx %0d val %h sing %b last %b, got %0d %h %b %b",
                     x.idx, x.val, x.sing, x.last, out_sol_index, out_sol_value,
                     out_singular, out_last);
        end
      end
    end
  end

  initial begin
    row_t tbl [$];
    int codes [$];
    logic [31:0] va [8][8];
    logic [31:0] vb [8];
    int n, style, zc, tmp, sw, reps;
    logic [3:0] ord;
    bit ready;

    errors = 0;
    items = 0;
    burst_left = 0;
    gappy = 0;
    typed_on = 0;
    typed_sing = 0;
    typed_val = 0;
    order_reg = 4'd8;
    for (int i = 0; i < 8; i++) begin
      wb[i] = 0;
      rhs[i] = 0;
      solved[i] = 0;
      for (int j = 0; j < 8; j++) begin
        wa[i][j] = 0;
        mat[i][j] = 0;
      end
    end
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    in_command = CMD_LOAD_A;
    in_row_index = '0;
    in_col_index = '0;
    in_value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tbl = {tbl, mk(1, CMD_LOAD_A, 0, 0, 32'd1)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 0, 32'h00010000)};
    tbl = {tbl, mk(0, CMD_LOAD_B, 0, 0, 32'h00020000)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0, 1, 32'h00020000, 0)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 0, 32'h0)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, 1)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 0, 32'h7fffffff)};
    tbl = {tbl, mk(0, CMD_LOAD_B, 0, 0, 32'h80000000)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 0, 32'h00000001)};
    tbl = {tbl, mk(0, CMD_LOAD_B, 0, 0, 32'h7fffffff)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0)};
    tbl = {tbl, mk(0, CMD_IGNORED, 7, 7, 32'hffffffff)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 0, 32'hffff0000)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0)};
    tbl = {tbl, mk(1, CMD_LOAD_A, 0, 0, 32'd0)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0)};
    tbl = {tbl, mk(1, CMD_LOAD_A, 0, 0, 32'd2)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 0, 1, 32'h00008000)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 1, 0, 32'hfffe0000)};
    tbl = {tbl, mk(0, CMD_LOAD_A, 1, 1, 32'h00030000)};
    tbl = {tbl, mk(0, CMD_LOAD_B, 1, 0, 32'h80000000)};
    tbl = {tbl, mk(0, CMD_SOLVE, 0, 0, 32'h0)};

    foreach (tbl[t]) begin
      if (tbl[t].is_cfg) begin
        write_order(tbl[t].val[3:0]);
      end else begin
        typed_on = tbl[t].typed;
        typed_val = tbl[t].xval;
        typed_sing = tbl[t].xsing;
        send(tbl[t].cmd, tbl[t].r, tbl[t].c, tbl[t].val);
        typed_on = 0;
      end
    end

    while (items < 330) begin
      case ($urandom_range(0, 9))
        0: begin
          tmp = $urandom_range(0, 7);
          ord = (tmp == 0) ? 4'd0 : 4'd8 + tmp[3:0];
        end
        1, 2: ord = 4'($urandom_range(5, 8));
        default: ord = 4'($urandom_range(1, 4));
      endcase
      write_order(ord);
      if ($urandom_range(0, 3) == 0) settle();
      n = (ord == 0) ? 1 : (ord > 8 ? 8 : ord);
      gappy = $urandom_range(0, 3) != 0;
      style = $urandom_range(0, 5);
      if (style > 3) style = 0;
      for (int i = 0; i < 8; i++) begin
        vb[i] = pick_value(style == 0 ? 1 : style, 0);
        for (int j = 0; j < 8; j++) va[i][j] = pick_value(style, i == j);
      end
      if ($urandom_range(0, 4) == 0) begin
        zc = $urandom_range(0, n - 1);
        for (int i = 0; i < 8; i++) va[i][zc] = 32'h0;
      end
      ready = 1;
      for (int i = 0; i < n; i++) begin
        if (!wb[i]) ready = 0;
        for (int j = 0; j < n; j++) if (!wa[i][j]) ready = 0;
      end
      codes.delete();
      for (int i = 0; i < n; i++) begin
        if (!ready || $urandom_range(0, 2) == 0) codes = {codes, 64 + i};
        for (int j = 0; j < n; j++)
          if (!ready || $urandom_range(0, 2) == 0) codes = {codes, i * 8 + j};
      end
      for (int i = codes.size() - 1; i > 0; i--) begin
        sw = $urandom_range(0, i);
        tmp = codes[i];
        codes[i] = codes[sw];
        codes[sw] = tmp;
      end
      foreach (codes[q]) begin
        if ($urandom_range(0, 9) == 0)
          send($urandom_range(0, 1) ? CMD_IGNORED : CMD_LOAD_A,
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
        if (codes[q] >= 64) send(CMD_LOAD_B, 3'(codes[q] - 64), 3'($urandom_range(0, 7)),
                                 vb[codes[q] - 64]);
        else send(CMD_LOAD_A, 3'(codes[q] / 8), 3'(codes[q] % 8),
                  va[codes[q] / 8][codes[q] % 8]);
      end
      reps = $urandom_range(0, 3) == 0 ? 2 : 1;
      repeat (reps) send(CMD_SOLVE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         $urandom);
    end

    settle();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* householder_qr_linear_solve.f */
design/hqr_pkg.sv
design/hqr_ram.sv
design/hqr_div.sv
design/hqr_isqrt.sv
design/householder_qr_linear_solve.sv
tb/householder_qr_linear_solve_test.sv
